// File: src/circular_double_ended_queue_assert.svh
// Assertion shorthands used by the deque RTL.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define CDEQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequent checked at the rising clock edge after the antecedent, outside reset.
`define CDEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/cdeq_pkg.sv
`default_nettype none

package cdeq_pkg;

    // Request codes
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_QUERY      = 3'd4;

    // Cell operations, one per chain
    localparam logic [1:0] CELL_HOLD     = 2'd0;
    localparam logic [1:0] CELL_SHIFT_UP = 2'd1;  // take the lower neighbour, insert at cell 0
    localparam logic [1:0] CELL_SHIFT_DN = 2'd2;  // take the upper neighbour
    localparam logic [1:0] CELL_WRITE_AT = 2'd3;  // write the word where index equals count

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        logic [31:0] front_value;
        logic [31:0] back_value;
        logic [7:0]  count;
        logic        is_empty;
        logic        is_full;
        logic        rejected;
    } t_rsp;

    // Front chain keeps the front entry in cell 0, back chain keeps the back entry there
    typedef struct packed {
        logic [1:0] f_op;
        logic [1:0] b_op;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: src/cdeq_cell.sv
`default_nettype none

module cdeq_cell
    import cdeq_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int CW         = 8,
    parameter int INDEX      = 0
) (
    input  wire logic                  i_clk,
    input  wire t_cell_ctl             i_ctl,
    input  wire logic [CW-1:0]         i_count,
    input  wire logic [DATA_WIDTH-1:0] i_word,
    input  wire logic [DATA_WIDTH-1:0] i_f_lo,
    input  wire logic [DATA_WIDTH-1:0] i_f_hi,
    input  wire logic [DATA_WIDTH-1:0] i_b_lo,
    input  wire logic [DATA_WIDTH-1:0] i_b_hi,
    output logic      [DATA_WIDTH-1:0] o_f,
    output logic      [DATA_WIDTH-1:0] o_b
);

    logic [DATA_WIDTH-1:0] r_f;
    logic [DATA_WIDTH-1:0] r_b;
    logic                  w_here;

    assign w_here = (i_count == CW'(INDEX));

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.f_op)
            CELL_HOLD:     r_f <= r_f;
            CELL_SHIFT_UP: r_f <= i_f_lo;
            CELL_SHIFT_DN: r_f <= i_f_hi;
            CELL_WRITE_AT: r_f <= w_here ? i_word : r_f;
        endcase
        unique case (i_ctl.b_op)
            CELL_HOLD:     r_b <= r_b;
            CELL_SHIFT_UP: r_b <= i_b_lo;
            CELL_SHIFT_DN: r_b <= i_b_hi;
            CELL_WRITE_AT: r_b <= w_here ? i_word : r_b;
        endcase
    end

    assign o_f = r_f;
    assign o_b = r_b;

endmodule

`default_nettype wire

// File: src/circular_double_ended_queue.sv
// The result strobe rises in the cycle after start is taken.
// Throughput: one request per cycle; busy stays low, and each request settles across
// the whole cell row at once.
// Reset: synchronous, active low; clears the count, the reject flag and the result
// strobe, stored words keep whatever they held. The receiver cannot stall the result.
`default_nettype none

`include "circular_double_ended_queue_assert.svh"

module circular_double_ended_queue
    import cdeq_pkg::*;
#(
    parameter int DEPTH      = 128,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_req i_req,
    output logic      busy,
    output logic      o_strobe,
    output t_rsp      o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_rejected;
    logic                  n_rejected;
    logic                  r_strobe;
    logic                  w_accept;
    logic                  w_full;
    logic                  w_empty;
    logic [DATA_WIDTH-1:0] w_word;
    t_cell_ctl             w_ctl;
    logic [DATA_WIDTH-1:0] w_f [DEPTH];
    logic [DATA_WIDTH-1:0] w_b [DEPTH];

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_empty  = (r_count == '0);
    assign w_word   = DATA_WIDTH'(i_req.value);

    always_comb begin
        w_ctl      = '{f_op: CELL_HOLD, b_op: CELL_HOLD};
        n_count    = r_count;
        n_rejected = 1'b0;
        if (w_accept) begin
            unique case (i_req.req_type)
                REQ_PUSH_FRONT: begin
                    if (w_full) begin
                        n_rejected = 1'b1;
                    end else begin
                        w_ctl   = '{f_op: CELL_SHIFT_UP, b_op: CELL_WRITE_AT};
                        n_count = r_count + 1'b1;
                    end
                end
                REQ_PUSH_BACK: begin
                    if (w_full) begin
                        n_rejected = 1'b1;
                    end else begin
                        w_ctl   = '{f_op: CELL_WRITE_AT, b_op: CELL_SHIFT_UP};
                        n_count = r_count + 1'b1;
                    end
                end
                REQ_POP_FRONT: begin
                    if (w_empty) begin
                        n_rejected = 1'b1;
                    end else begin
                        // back chain drops its top entry through the count alone
                        w_ctl   = '{f_op: CELL_SHIFT_DN, b_op: CELL_HOLD};
                        n_count = r_count - 1'b1;
                    end
                end
                REQ_POP_BACK: begin
                    if (w_empty) begin
                        n_rejected = 1'b1;
                    end else begin
                        w_ctl   = '{f_op: CELL_HOLD, b_op: CELL_SHIFT_DN};
                        n_count = r_count - 1'b1;
                    end
                end
                REQ_QUERY: begin
                    n_count = r_count;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_rejected <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_rejected <= n_rejected;
            r_strobe   <= w_accept;
        end
    end

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_f_lo;
        logic [DATA_WIDTH-1:0] w_f_hi;
        logic [DATA_WIDTH-1:0] w_b_lo;
        logic [DATA_WIDTH-1:0] w_b_hi;

        if (gi == 0) begin : g_first
            assign w_f_lo = w_word;
            assign w_b_lo = w_word;
        end else begin : g_mid_lo
            assign w_f_lo = w_f[gi-1];
            assign w_b_lo = w_b[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_last
            assign w_f_hi = '0;
            assign w_b_hi = '0;
        end else begin : g_mid_hi
            assign w_f_hi = w_f[gi+1];
            assign w_b_hi = w_b[gi+1];
        end

        cdeq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CW         (CW),
            .INDEX      (gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_count (r_count),
            .i_word  (w_word),
            .i_f_lo  (w_f_lo),
            .i_f_hi  (w_f_hi),
            .i_b_lo  (w_b_lo),
            .i_b_hi  (w_b_hi),
            .o_f     (w_f[gi]),
            .o_b     (w_b[gi])
        );
    end

    assign o_strobe          = r_strobe;
    assign o_rsp.front_value = w_empty ? 32'd0 : 32'(w_f[0]);
    assign o_rsp.back_value  = w_empty ? 32'd0 : 32'(w_b[0]);
    assign o_rsp.count       = 8'(r_count);
    assign o_rsp.is_empty    = w_empty;
    assign o_rsp.is_full     = w_full;
    assign o_rsp.rejected    = r_rejected;

    `CDEQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "count beyond depth")
    `CDEQ_ASSERT_NEXT(a_strobe_follows, i_clk, i_rst_n, w_accept, r_strobe, "missing result strobe")
    `CDEQ_ASSERT(a_count_moves_on_accept, i_clk, i_rst_n, ($past(i_rst_n) && r_count != $past(r_count)) |-> $past(w_accept), "count moved without a transaction")
    `CDEQ_ASSERT(a_reject_holds_count, i_clk, i_rst_n, ($past(i_rst_n) && r_strobe && r_rejected) |-> (r_count == $past(r_count)), "rejected transaction changed count")
    `CDEQ_ASSERT(a_reject_only_on_strobe, i_clk, i_rst_n, r_rejected |-> r_strobe, "reject flag without result")

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import cdeq_pkg::*;

    localparam int DEPTH        = 128;
    localparam int RAND_ITEMS   = 1280;
    localparam int SEG_LEN      = 160;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 4;

    // Codes outside the defined set behave as a plain query
    localparam logic [2:0] REQ_UNUSED_5 = 3'd5;
    localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    typedef struct {
        t_req        req;
        int unsigned idle_pct;
        bit          hold_for_drain;
    } t_stim;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_strobe;
    t_rsp o_rsp;

    t_stim req_backlog[$];
    t_rsp  views_due[$];
    t_stim next_item;
    t_rsp  want;
    bit    rst_done = 1'b0;
    bit    taken    = 1'b0;
    bit    failed   = 1'b0;
    int    cycles   = 0;

    // Shadow deque state
    logic [31:0] q_store [DEPTH];
    logic [6:0]  q_head;
    logic [6:0]  q_tail;
    logic [7:0]  q_count;

    circular_double_ended_queue uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_rsp   (o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_rsp apply_request(t_req rq);
        t_rsp       view;
        logic       full;
        logic       empty;
        logic [6:0] last;
        view  = '0;
        full  = (q_count == DEPTH);
        empty = (q_count == 0);
        case (rq.req_type)
            REQ_PUSH_FRONT: begin
                if (full) begin
                    view.rejected = 1'b1;
                end else begin
                    q_head = q_head - 7'd1;
                    q_store[q_head] = rq.value;
                    q_count = q_count + 8'd1;
                end
            end
            REQ_PUSH_BACK: begin
                if (full) begin
                    view.rejected = 1'b1;
                end else begin
                    q_store[q_tail] = rq.value;
                    q_tail = q_tail + 7'd1;
                    q_count = q_count + 8'd1;
                end
            end
            REQ_POP_FRONT: begin
                if (empty) begin
                    view.rejected = 1'b1;
                end else begin
                    q_head = q_head + 7'd1;
                    q_count = q_count - 8'd1;
                end
            end
            REQ_POP_BACK: begin
                if (empty) begin
                    view.rejected = 1'b1;
                end else begin
                    q_tail = q_tail - 7'd1;
                    q_count = q_count - 8'd1;
                end
            end
            default: ;
        endcase
        if (q_count != 0) begin
            last = q_tail - 7'd1;
            view.front_value = q_store[q_head];
            view.back_value  = q_store[last];
        end
        view.count    = q_count;
        view.is_empty = (q_count == 0);
        view.is_full  = (q_count == DEPTH);
        return view;
    endfunction

    function automatic logic [31:0] pick_word();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) return 32'h0000_0000;
        if (r == 1) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic logic [2:0] pick_code(t_mix mix);
        int unsigned r;
        int unsigned push_lim;
        int unsigned pop_lim;
        r = $urandom_range(99);
        case (mix)
            MIX_FILL:  begin push_lim = 85; pop_lim = 95; end
            MIX_DRAIN: begin push_lim = 10; pop_lim = 95; end
            default:   begin push_lim = 42; pop_lim = 84; end
        endcase
        if (r < push_lim) return $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        if (r < pop_lim)  return $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
        return 3'(REQ_QUERY + $urandom_range(3));
    endfunction

    function automatic void add_item(logic [2:0] code, logic [31:0] word,
                                     int unsigned idle, bit hold);
        t_stim s;
        s.req.req_type   = code;
        s.req.value      = word;
        s.idle_pct       = idle;
        s.hold_for_drain = hold;
        req_backlog.insert(req_backlog.size(), s);
    endfunction

    // Driver: at most one transaction offered per cycle, with random idle cycles, held until taken
    always @(negedge i_clk) begin
        if (rst_done && !(start && !taken)) begin
            if (req_backlog.size() != 0
                && !(req_backlog[0].hold_for_drain && views_due.size() != 0)
                && $urandom_range(99) >= req_backlog[0].idle_pct) begin
                next_item = req_backlog[0];
                req_backlog.delete(0);
                start <= 1'b1;
                i_req <= next_item.req;
            end else begin
                start <= 1'b0;
                i_req <= {3'($urandom), 32'($urandom)};
            end
            taken = 1'b0;
        end
    end

    // Monitor: predict on acceptance, then check any result in this cycle
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                views_due.insert(views_due.size(), apply_request(i_req));
                taken = 1'b1;
            end
            if (o_strobe) begin
                if (views_due.size() == 0) begin
                    $error("result with no transaction outstanding");
                    failed = 1'b1;
                end else begin
                    want = views_due[0];
                    views_due.delete(0);
                    if (o_rsp.front_value !== want.front_value) begin
                        $error("front_value: expected %h, got %h",
                               want.front_value, o_rsp.front_value);
                        failed = 1'b1;
                    end
                    if (o_rsp.back_value !== want.back_value) begin
                        $error("back_value: expected %h, got %h",
                               want.back_value, o_rsp.back_value);
                        failed = 1'b1;
                    end
                    if (o_rsp.count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, o_rsp.count);
                        failed = 1'b1;
                    end
                    if (o_rsp.is_empty !== want.is_empty) begin
                        $error("is_empty: expected %b, got %b",
                               want.is_empty, o_rsp.is_empty);
                        failed = 1'b1;
                    end
                    if (o_rsp.is_full !== want.is_full) begin
                        $error("is_full: expected %b, got %b", want.is_full, o_rsp.is_full);
                        failed = 1'b1;
                    end
                    if (o_rsp.rejected !== want.rejected) begin
                        $error("rejected: expected %b, got %b",
                               want.rejected, o_rsp.rejected);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        t_mix        seg_mix [8];
        int unsigned phase;
        int unsigned idle;
        bit          hold;
        seg_mix = '{MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_FILL,
                    MIX_EVEN, MIX_DRAIN, MIX_FILL, MIX_DRAIN};
        q_head  = '0;
        q_tail  = '0;
        q_count = '0;

        // Empty queue, rejected pops, spare codes
        add_item(REQ_QUERY,      32'h1234_5678, 17, 1'b0);
        add_item(REQ_POP_FRONT,  32'hFFFF_FFFF, 17, 1'b0);
        add_item(REQ_POP_BACK,   32'h0000_0000, 17, 1'b0);
        add_item(REQ_UNUSED_5,   32'hDEAD_BEEF, 17, 1'b0);
        // Extreme words at both ends
        add_item(REQ_PUSH_BACK,  32'h0000_0000, 17, 1'b0);
        add_item(REQ_PUSH_FRONT, 32'hFFFF_FFFF, 17, 1'b0);
        add_item(REQ_PUSH_BACK,  32'hA5A5_A5A5, 17, 1'b0);
        add_item(REQ_PUSH_FRONT, 32'h5A5A_5A5A, 17, 1'b0);
        add_item(REQ_QUERY,      32'h0000_0000, 17, 1'b0);
        add_item(REQ_UNUSED_6,   32'hFFFF_FFFF, 17, 1'b0);
        add_item(REQ_UNUSED_7,   32'h8000_0001, 17, 1'b0);
        add_item(REQ_POP_FRONT,  32'h0000_0000, 17, 1'b0);
        add_item(REQ_POP_BACK,   32'h0000_0000, 17, 1'b0);
        add_item(REQ_POP_BACK,   32'h0000_0000, 17, 1'b0);
        add_item(REQ_POP_FRONT,  32'h0000_0000, 17, 1'b0);
        add_item(REQ_POP_BACK,   32'hFFFF_FFFF, 17, 1'b0);
        // Single entry: front and back are the same word
        add_item(REQ_PUSH_FRONT, 32'h0000_0001, 17, 1'b0);
        add_item(REQ_POP_BACK,   32'h0000_0000, 17, 1'b0);
        add_item(REQ_PUSH_BACK,  32'h8000_0000, 17, 1'b0);
        add_item(REQ_POP_FRONT,  32'h0000_0000, 17, 1'b0);
        add_item(REQ_POP_FRONT,  32'h0000_0000, 17, 1'b0);

        // Random bursts biased to fill past full, drain past empty, or wander
        for (int i = 0; i < RAND_ITEMS; i++) begin
            phase = (i * 3) / RAND_ITEMS;
            case (phase)
                0:       idle = 17;
                1:       idle = 65;
                default: idle = 0;
            endcase
            hold = (i % (RAND_ITEMS / 3) == 0) || ($urandom_range(149) == 0);
            add_item(pick_code(seg_mix[(i / SEG_LEN) % 8]), pick_word(), idle, hold);
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;

        wait (req_backlog.size() == 0 && !start);
        @(posedge i_clk);
        wait (views_due.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (!failed) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
